/* src/cosine_eased_waypoint_sequencer_unit_macros.svh */
// Assertion helpers shared by the sequencer modules.
// Each macro expects clk and arst_n in scope.
`ifndef COSINE_EASED_WAYPOINT_SEQUENCER_UNIT_MACROS_SVH
`define COSINE_EASED_WAYPOINT_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define CEWS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// Next-cycle implication.
`define CEWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`endif

/* src/cews_pkg.sv */
`default_nettype none
package cews_pkg;

	localparam int PROGRESS_BITS = 10;
	localparam int TICK_BITS     = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int HEIGHT_W      = 16;
	localparam int CMP_W         = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
	localparam int EASE_DEPTH    = 1 << PROGRESS_BITS;
	localparam int EASE_W        = 17;
	localparam int DH_W          = HEIGHT_W + 1;
	localparam int PROD_W        = DH_W + EASE_W + 1;
	localparam int DIV_CNT_W     = $clog2(PROGRESS_BITS);
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_ROM,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		PH_HOVER   = 3'd0,
		PH_DESCEND = 3'd1,
		PH_CLOSE   = 3'd2,
		PH_LIFT    = 3'd3,
		PH_HOLD    = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOVER_HEIGHT       = 3'd0,
		CFG_GRASP_HEIGHT       = 3'd1,
		CFG_LIFT_HEIGHT        = 3'd2,
		CFG_DESCEND_START_TICK = 3'd3,
		CFG_DESCEND_END_TICK   = 3'd4,
		CFG_CLOSE_END_TICK     = 3'd5,
		CFG_LIFT_END_TICK      = 3'd6
	} cfg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic setup;
		logic div_step;
		logic rom_rd;
		logic mul;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic eased;
		logic out_free;
	} status_t;

	typedef logic [EASE_W-1:0] ease_rom_t [EASE_DEPTH];

	// (a * b) >> 62, Q62 operands
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[125:62];
	endfunction

	// floor(num / den) by shift and subtract; den nonzero
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// round(65536 * sin^2(pi * k / 2^(PROGRESS_BITS+1))), Taylor series in Q62
	function automatic logic [EASE_W-1:0] ease_weight(input logic [63:0] k);
		logic [63:0] mask;
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] sq;
		mask = (64'd1 << (PROGRESS_BITS + 1)) - 64'd1;
		th   = (PI_Q62 >> (PROGRESS_BITS + 1)) * k
			+ (((PI_Q62 & mask) * k) >> (PROGRESS_BITS + 1));
		th2  = mul_q62(th, th);
		term = th;
		s    = th;
		for (int n = 1; n <= 15; n++) begin
			term = udiv64(mul_q62(term, th2), 64'(2 * n) * 64'(2 * n + 1));
			if (n % 2 == 1) begin
				s = s - term;
			end else begin
				s = s + term;
			end
		end
		sq = mul_q62(s, s) + (64'd1 << 45);
		return sq[46 +: EASE_W];
	endfunction

	function automatic ease_rom_t build_ease_rom();
		ease_rom_t rom;
		for (int k = 0; k < EASE_DEPTH; k++) begin
			rom[k] = ease_weight(64'(k));
		end
		return rom;
	endfunction

endpackage
`default_nettype wire

/* src/cews_ctrl.sv */
`default_nettype none
`include "cosine_eased_waypoint_sequencer_unit_macros.svh"
module cews_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire cews_pkg::status_t status,
	output logic                  in_stall,
	output cews_pkg::cmd_t        cmd
);

	cews_pkg::state_t state_q, state_nxt;
	logic [cews_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic div_last;

	assign div_last = (div_cnt_q == cews_pkg::DIV_CNT_W'(cews_pkg::PROGRESS_BITS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cews_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = cews_pkg::ST_SETUP;
			end
			cews_pkg::ST_SETUP: begin
				state_nxt = status.eased ? cews_pkg::ST_DIV : cews_pkg::ST_FIN;
			end
			cews_pkg::ST_DIV: begin
				if (div_last) state_nxt = cews_pkg::ST_ROM;
			end
			cews_pkg::ST_ROM: state_nxt = cews_pkg::ST_MUL;
			cews_pkg::ST_MUL: state_nxt = cews_pkg::ST_FIN;
			cews_pkg::ST_FIN: begin
				if (status.out_free) state_nxt = cews_pkg::ST_IDLE;
			end
			default: state_nxt = cews_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == cews_pkg::ST_IDLE) && in_valid;
		cmd.setup    = (state_q == cews_pkg::ST_SETUP);
		cmd.div_step = (state_q == cews_pkg::ST_DIV);
		cmd.rom_rd   = (state_q == cews_pkg::ST_ROM);
		cmd.mul      = (state_q == cews_pkg::ST_MUL);
		cmd.load_out = (state_q == cews_pkg::ST_FIN) && status.out_free;
	end

	assign in_stall = (state_q != cews_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cews_pkg::ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == cews_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + cews_pkg::DIV_CNT_W'(1);
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	`CEWS_ASSERT_NEXT(a_accept_to_setup, cmd.accept, state_q == cews_pkg::ST_SETUP)
	`CEWS_ASSERT_NOW(a_div_cnt_range, state_q == cews_pkg::ST_DIV, div_cnt_q <= cews_pkg::DIV_CNT_W'(cews_pkg::PROGRESS_BITS - 1))
	`CEWS_ASSERT_NEXT(a_load_returns_idle, cmd.load_out, state_q == cews_pkg::ST_IDLE)

endmodule
`default_nettype wire

/* src/cews_dp.sv */
`default_nettype none
`include "cosine_eased_waypoint_sequencer_unit_macros.svh"
module cews_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [cews_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cews_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                             restart,
	input  wire cews_pkg::cmd_t                   cmd,
	input  wire logic                             out_stall,
	output cews_pkg::status_t                     status,
	output logic                                  out_valid,
	output logic signed [cews_pkg::HEIGHT_W-1:0]  height,
	output logic                                  gripper_closed,
	output logic [2:0]                            phase
);

	localparam cews_pkg::ease_rom_t EaseRom = cews_pkg::build_ease_rom();
	localparam int CW = cews_pkg::CMP_W;
	localparam int PB = cews_pkg::PROGRESS_BITS;
	localparam logic [cews_pkg::TICK_BITS-1:0] TickMax = '1;

	// configuration
	logic signed [cews_pkg::HEIGHT_W-1:0] hover_q, grasp_q, lift_q;
	logic [cews_pkg::CFG_W-1:0] ds_q, de_q, ce_q, le_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hover_q <= 16'sd5000;
			grasp_q <= 16'sd1450;
			lift_q  <= 16'sd4500;
			ds_q    <= 16'd60;
			de_q    <= 16'd160;
			ce_q    <= 16'd190;
			le_q    <= 16'd280;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cews_pkg::CFG_HOVER_HEIGHT:       hover_q <= $signed(cfg_data);
				cews_pkg::CFG_GRASP_HEIGHT:       grasp_q <= $signed(cfg_data);
				cews_pkg::CFG_LIFT_HEIGHT:        lift_q  <= $signed(cfg_data);
				cews_pkg::CFG_DESCEND_START_TICK: ds_q    <= cfg_data;
				cews_pkg::CFG_DESCEND_END_TICK:   de_q    <= cfg_data;
				cews_pkg::CFG_CLOSE_END_TICK:     ce_q    <= cfg_data;
				cews_pkg::CFG_LIFT_END_TICK:      le_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick counter and phase pick
	logic [cews_pkg::TICK_BITS-1:0] tick_q, t_cur;
	logic [CW-1:0] t_ext;
	cews_pkg::phase_t ph_sel;
	logic signed [cews_pkg::HEIGHT_W-1:0] h0_sel, h1_sel;
	logic [CW-1:0] t0_sel, t1_sel;

	assign t_cur = restart ? '0 : tick_q;
	assign t_ext = CW'(t_cur);

	always_comb begin
		h1_sel = grasp_q;
		t0_sel = CW'(ds_q);
		t1_sel = CW'(de_q);
		priority if (t_ext < CW'(ds_q)) begin
			ph_sel = cews_pkg::PH_HOVER;
			h0_sel = hover_q;
		end else if (t_ext < CW'(de_q)) begin
			ph_sel = cews_pkg::PH_DESCEND;
			h0_sel = hover_q;
		end else if (t_ext < CW'(ce_q)) begin
			ph_sel = cews_pkg::PH_CLOSE;
			h0_sel = grasp_q;
		end else if (t_ext < CW'(le_q)) begin
			ph_sel = cews_pkg::PH_LIFT;
			h0_sel = grasp_q;
			h1_sel = lift_q;
			t0_sel = CW'(ce_q);
			t1_sel = CW'(le_q);
		end else begin
			ph_sel = cews_pkg::PH_HOLD;
			h0_sel = lift_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (cmd.accept) begin
			tick_q <= (t_cur == TickMax) ? t_cur : t_cur + cews_pkg::TICK_BITS'(1);
		end
	end

	cews_pkg::phase_t phase_q;
	logic [CW-1:0] t_q, t0_q, t1_q;
	logic signed [cews_pkg::HEIGHT_W-1:0] h0_q, h1_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			phase_q <= ph_sel;
			t_q     <= t_ext;
			t0_q    <= t0_sel;
			t1_q    <= t1_sel;
			h0_q    <= h0_sel;
			h1_q    <= h1_sel;
		end
	end

	// restoring divider: one quotient bit per cycle
	logic [CW:0] rem_q, rem_sh, rem_sub;
	logic [CW-1:0] den_q;
	logic [PB-1:0] quo_q;
	logic signed [cews_pkg::DH_W-1:0] dh_q;
	logic rem_ge;

	assign rem_sh  = {rem_q[CW-1:0], 1'b0};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign rem_ge  = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			rem_q <= {1'b0, t_q - t0_q};
			den_q <= t1_q - t0_q;
			quo_q <= '0;
			dh_q  <= $signed({h1_q[cews_pkg::HEIGHT_W-1], h1_q})
				- $signed({h0_q[cews_pkg::HEIGHT_W-1], h0_q});
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub : rem_sh;
			quo_q <= {quo_q[PB-2:0], rem_ge};
		end
	end

	// ease weight lookup and scale
	logic [cews_pkg::EASE_W-1:0] e_q;
	logic signed [cews_pkg::PROD_W-1:0] prod_q, prod_sh;
	logic signed [cews_pkg::DH_W-1:0] z_sum;
	logic signed [cews_pkg::HEIGHT_W-1:0] h_fin;

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			e_q <= EaseRom[quo_q];
		end
		if (cmd.mul) begin
			prod_q <= dh_q * $signed({1'b0, e_q});
		end
	end

	// floor shift; result stays between the two heights
	assign prod_sh = prod_q >>> 16;
	assign z_sum   = $signed({h0_q[cews_pkg::HEIGHT_W-1], h0_q})
		+ $signed(prod_sh[cews_pkg::DH_W-1:0]);
	assign h_fin   = status.eased ? z_sum[cews_pkg::HEIGHT_W-1:0] : h0_q;

	// output register
	logic out_valid_q, grip_q;
	logic signed [cews_pkg::HEIGHT_W-1:0] height_q;
	logic [2:0] phase_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			height_q    <= h_fin;
			grip_q      <= (phase_q != cews_pkg::PH_HOVER) && (phase_q != cews_pkg::PH_DESCEND);
			phase_out_q <= phase_q;
		end
	end

	assign status.eased    = (phase_q == cews_pkg::PH_DESCEND) || (phase_q == cews_pkg::PH_LIFT);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign height         = height_q;
	assign gripper_closed = grip_q;
	assign phase          = phase_out_q;

	`CEWS_ASSERT_NOW(a_rem_below_den, cmd.div_step, rem_q < {1'b0, den_q})
	`CEWS_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_q)
	`CEWS_ASSERT_NEXT(a_tick_advance, cmd.accept && !restart && (tick_q != TickMax), tick_q == $past(tick_q) + cews_pkg::TICK_BITS'(1))
	`CEWS_ASSERT_NEXT(a_tick_restart, cmd.accept && restart, tick_q == cews_pkg::TICK_BITS'(1))

endmodule
`default_nettype wire

/* src/cosine_eased_waypoint_sequencer_unit.sv */
`default_nettype none
// Raised-cosine S-curve height sequencer. Every input transfer is one timer
// tick and yields exactly one output transfer: a signed height setpoint in
// 0.1 mm, the gripper flag and the phase code (hover, descend, close, lift,
// hold). The tick counter saturates at its maximum; a tick with restart set
// counts from zero. In descend and lift the height eases from start to
// target along 0.5*(1-cos); the progress fraction comes from a restoring
// divider that produces one quotient bit per cycle, and the weight from a
// registered lookup table. An eased tick passes through setup, PROGRESS_BITS
// divide steps, lookup, scale and finish before its result reaches the
// output register; a flat tick passes through setup and finish only. The
// finish step waits for the output register to free up, so a held output
// delays it. The next tick is taken only once the result is in the output
// register, while that result may still wait for its output transfer.
// Configuration writes are taken at any time but belong in idle periods.
module cosine_eased_waypoint_sequencer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [cews_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cews_pkg::CFG_W-1:0]       cfg_data,
	// tick channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             restart,
	// setpoint channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [cews_pkg::HEIGHT_W-1:0]  height,
	output logic                                  gripper_closed,
	output logic [2:0]                            phase
);

	cews_pkg::cmd_t    cmd;
	cews_pkg::status_t status;

	// sequencing: accept, setup, divide, lookup, scale, finish
	cews_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// counter, phase compare, divider, table, multiplier, output register
	cews_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.restart        (restart),
		.cmd            (cmd),
		.out_stall      (out_stall),
		.status         (status),
		.out_valid      (out_valid),
		.height         (height),
		.gripper_closed (gripper_closed),
		.phase          (phase)
	);

endmodule
`default_nettype wire
